// ----- sv/drs_pkg.sv -----
// Shared constants and types for the disk request scheduler.
// Holds request, status, policy and register codes and the controller state type.
// No dependencies.
package drs_pkg;

    localparam int TAG_BITS        = 8;
    localparam int AGE_BITS        = 32;
    localparam int STEP_BITS       = 40;
    localparam int STATUS_BITS     = 3;
    localparam int COUNT_OUT_BITS  = 5;
    localparam int POLICY_BITS     = 2;

    // Request types.
    localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
    localparam logic [1:0] REQ_DISPATCH = 2'd1;
    localparam logic [1:0] REQ_COMPLETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_ACCEPTED   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_DISPATCHED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_BUSY       = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_COMPLETED  = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_ERROR      = 3'd6;

    // Selection policies.
    localparam logic [POLICY_BITS-1:0] POL_FCFS  = 2'd0;
    localparam logic [POLICY_BITS-1:0] POL_SSTF  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POL_CSCAN = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_POLICY     = 1'b0;
    localparam logic CFG_NUM_BLOCKS = 1'b1;

    // One table read issued toward the selector.
    typedef struct packed {
        logic go;
        logic occupied;
    } drs_issue_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FREE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } drs_state_t;

endpackage

// ----- sv/disk_request_scheduler_top.sv -----
// Refused requests and completions go straight to the result register; an accepted enqueue
// first searches for the lowest free slot, and a dispatch scans every table entry and waits
// for the selector to drain before it delivers its beat.
// Throughput: one request at a time; a dispatch is bounded by the table scan through the
// single read port of the entry RAM, one entry per cycle.
// Reset: asynchronous, active low; clears the valid bits, counters, head and step total.
// The entry RAM holds no reset state and needs no clearing pass.
module disk_request_scheduler_top
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int BLOCK_BITS  = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_en,
    input  logic                      cfg_index,
    input  logic [BLOCK_BITS:0]       cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                req_type,
    input  logic [BLOCK_BITS-1:0]     req_block,
    input  logic                      req_write,
    input  logic [TAG_BITS-1:0]       req_tag,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [STATUS_BITS-1:0]    status,
    output logic [BLOCK_BITS-1:0]     grant_block,
    output logic                      grant_write,
    output logic [TAG_BITS-1:0]       grant_tag,
    output logic [BLOCK_BITS-1:0]     cur_head,
    output logic [STEP_BITS-1:0]      seek_total,
    output logic [COUNT_OUT_BITS-1:0] pending_count
);

    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = BLOCK_BITS + TAG_BITS + AGE_BITS + 1;

    drs_state_t state_reg, state_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [AGE_BITS-1:0]    arrival_reg, arrival_next;
    logic                   busy_reg, busy_next;
    logic [BLOCK_BITS-1:0]  head_reg, head_next;
    logic [STEP_BITS-1:0]   steps_reg, steps_next;
    logic [POLICY_BITS-1:0] policy_reg, policy_next;
    logic [BLOCK_BITS:0]    nblocks_reg, nblocks_next;
    logic                   out_valid_reg, out_valid_next;

    logic [BLOCK_BITS-1:0]  item_block_reg, item_block_next;
    logic                   item_write_reg, item_write_next;
    logic [TAG_BITS-1:0]    item_tag_reg, item_tag_next;
    logic [BLOCK_BITS-1:0]  svc_block_reg, svc_block_next;
    logic                   svc_write_reg, svc_write_next;
    logic [TAG_BITS-1:0]    svc_tag_reg, svc_tag_next;
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [BLOCK_BITS-1:0]  res_block_reg, res_block_next;
    logic                   res_write_reg, res_write_next;
    logic [TAG_BITS-1:0]    res_tag_reg, res_tag_next;

    logic [STATUS_BITS-1:0]    out_status_reg, out_status_next;
    logic [BLOCK_BITS-1:0]     out_block_reg, out_block_next;
    logic                      out_write_reg, out_write_next;
    logic [TAG_BITS-1:0]       out_tag_reg, out_tag_next;
    logic [BLOCK_BITS-1:0]     out_head_reg, out_head_next;
    logic [STEP_BITS-1:0]      out_steps_reg, out_steps_next;
    logic [COUNT_OUT_BITS-1:0] out_count_reg, out_count_next;

    logic                  accept;
    logic [BLOCK_BITS-1:0] travel;
    logic [STEP_BITS:0]    step_sum;
    logic [CNT_W+COUNT_OUT_BITS-1:0] count_ext;

    logic                  ram_we;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  sel_start;
    drs_issue_t            sel_issue;
    logic                  sel_busy;
    logic                  sel_found;
    logic [SLOT_W-1:0]     sel_slot;
    logic [BLOCK_BITS-1:0] sel_block;
    logic                  sel_write;
    logic [TAG_BITS-1:0]   sel_tag;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign ram_we    = (state_reg == S_FREE) && !valid_reg[idx_reg];
    assign ram_re    = (state_reg == S_SCAN);
    assign ram_wdata = {arrival_reg, item_tag_reg, item_write_reg, item_block_reg};

    assign sel_issue.go       = (state_reg == S_SCAN);
    assign sel_issue.occupied = valid_reg[idx_reg];

    drs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    drs_select #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (sel_start),
        .issue      (sel_issue),
        .issue_slot (idx_reg),
        .rdata      (ram_rdata),
        .head       (head_reg),
        .policy     (policy_reg),
        .arrival    (arrival_reg),
        .busy       (sel_busy),
        .found      (sel_found),
        .best_slot  (sel_slot),
        .best_block (sel_block),
        .best_write (sel_write),
        .best_tag   (sel_tag)
    );

    always_comb
    begin
        travel    = (head_reg > svc_block_reg) ? (head_reg - svc_block_reg)
                                               : (svc_block_reg - head_reg);
        step_sum  = {1'b0, steps_reg} + (STEP_BITS+1)'(travel);
        count_ext = (CNT_W+COUNT_OUT_BITS)'(count_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        arrival_next    = arrival_reg;
        busy_next       = busy_reg;
        head_next       = head_reg;
        steps_next      = steps_reg;
        item_block_next = item_block_reg;
        item_write_next = item_write_reg;
        item_tag_next   = item_tag_reg;
        svc_block_next  = svc_block_reg;
        svc_write_next  = svc_write_reg;
        svc_tag_next    = svc_tag_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        res_write_next  = res_write_reg;
        res_tag_next    = res_tag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_write_next  = out_write_reg;
        out_tag_next    = out_tag_reg;
        out_head_next   = out_head_reg;
        out_steps_next  = out_steps_reg;
        out_count_next  = out_count_reg;
        sel_start       = 1'b0;

        policy_next  = policy_reg;
        nblocks_next = nblocks_reg;
        if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_POLICY:     policy_next  = cfg_data[POLICY_BITS-1:0];
                CFG_NUM_BLOCKS: nblocks_next = cfg_data;
                default:        policy_next  = policy_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_block_next = req_block;
                    item_write_next = req_write;
                    item_tag_next   = req_tag;
                    res_block_next  = '0;
                    res_write_next  = 1'b0;
                    res_tag_next    = '0;
                    res_status_next = ST_ERROR;
                    idx_next        = '0;
                    state_next      = S_DONE;
                    priority case (req_type)
                        REQ_ENQUEUE:
                        begin
                            // The range check wins over the full check.
                            if ({1'b0, req_block} >= nblocks_reg)
                            begin
                                res_status_next = ST_ERROR;
                            end
                            else if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        REQ_DISPATCH:
                        begin
                            if (busy_reg)
                            begin
                                res_status_next = ST_BUSY;
                            end
                            else if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                sel_start  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_COMPLETE:
                        begin
                            if (busy_reg)
                            begin
                                steps_next      = step_sum[STEP_BITS] ? '1
                                                  : step_sum[STEP_BITS-1:0];
                                head_next       = svc_block_reg;
                                busy_next       = 1'b0;
                                res_status_next = ST_COMPLETED;
                                res_block_next  = svc_block_reg;
                                res_write_next  = svc_write_reg;
                                res_tag_next    = svc_tag_reg;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_ERROR;
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    arrival_next        = arrival_reg + 1'b1;
                    res_status_next     = ST_ACCEPTED;
                    state_next          = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == SLOT_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!sel_busy)
                begin
                    valid_next[sel_slot] = 1'b0;
                    count_next           = count_reg - 1'b1;
                    busy_next            = 1'b1;
                    svc_block_next       = sel_block;
                    svc_write_next       = sel_write;
                    svc_tag_next         = sel_tag;
                    res_status_next      = ST_DISPATCHED;
                    res_block_next       = sel_block;
                    res_write_next       = sel_write;
                    res_tag_next         = sel_tag;
                    state_next           = S_DONE;
                end
            end
            S_DONE:
            begin
                // The output register frees up in the same cycle its beat is taken.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    out_write_next  = res_write_reg;
                    out_tag_next    = res_tag_reg;
                    out_head_next   = head_reg;
                    out_steps_next  = steps_reg;
                    out_count_next  = count_ext[COUNT_OUT_BITS-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            count_reg     <= '0;
            arrival_reg   <= '0;
            busy_reg      <= 1'b0;
            head_reg      <= '0;
            steps_reg     <= '0;
            policy_reg    <= POL_CSCAN;
            nblocks_reg   <= {1'b1, {BLOCK_BITS{1'b0}}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            arrival_reg   <= arrival_next;
            busy_reg      <= busy_next;
            head_reg      <= head_next;
            steps_reg     <= steps_next;
            policy_reg    <= policy_next;
            nblocks_reg   <= nblocks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_block_reg <= item_block_next;
        item_write_reg <= item_write_next;
        item_tag_reg   <= item_tag_next;
        svc_block_reg  <= svc_block_next;
        svc_write_reg  <= svc_write_next;
        svc_tag_reg    <= svc_tag_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        res_write_reg  <= res_write_next;
        res_tag_reg    <= res_tag_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_write_reg  <= out_write_next;
        out_tag_reg    <= out_tag_next;
        out_head_reg   <= out_head_next;
        out_steps_reg  <= out_steps_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign grant_block   = out_block_reg;
    assign grant_write   = out_write_reg;
    assign grant_tag     = out_tag_reg;
    assign cur_head      = out_head_reg;
    assign seek_total    = out_steps_reg;
    assign pending_count = out_count_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("pending count differs from the number of valid entries");

    a_free_scan_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |-> (count_reg < CNT_W'(QUEUE_DEPTH)))
        else $error("free slot search started on a full table");

    a_drain_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && !sel_busy) |-> sel_found)
        else $error("dispatch scan ended without a candidate");

    a_busy_dispatch_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_DISPATCH && busy_reg)
        |=> (state_reg == S_DONE && res_status_reg == ST_BUSY))
        else $error("dispatch while busy was not refused");
`endif

endmodule

// ----- sv/drs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module drs_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/drs_select.sv -----
// Selection pipeline: turns a stream of table entries into the best candidate.
// Depends on drs_pkg; fed by the entry table RAM read port.
module drs_select
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int BLOCK_BITS  = 16
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  drs_issue_t                                issue,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]            issue_slot,
    input  logic [BLOCK_BITS+TAG_BITS+AGE_BITS:0]     rdata,
    input  logic [BLOCK_BITS-1:0]                     head,
    input  logic [POLICY_BITS-1:0]                    policy,
    input  logic [AGE_BITS-1:0]                       arrival,
    output logic                                      busy,
    output logic                                      found,
    output logic [$clog2(QUEUE_DEPTH)-1:0]            best_slot,
    output logic [BLOCK_BITS-1:0]                     best_block,
    output logic                                      best_write,
    output logic [TAG_BITS-1:0]                       best_tag
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int PRIM_W = BLOCK_BITS + 1;

    // Stage A: aligned with the RAM read data.
    drs_issue_t        a_issue_reg;
    logic [SLOT_W-1:0] a_slot_reg;

    // Stage B: keys of one occupied entry.
    logic                  b_vld_reg;
    logic [PRIM_W-1:0]     b_prim_reg;
    logic [AGE_BITS-1:0]   b_back_reg;
    logic [SLOT_W-1:0]     b_slot_reg;
    logic [BLOCK_BITS-1:0] b_block_reg;
    logic                  b_write_reg;
    logic [TAG_BITS-1:0]   b_tag_reg;

    // Best candidate so far.
    logic                  found_reg;
    logic                  found_next;
    logic [PRIM_W-1:0]     best_prim_reg;
    logic [AGE_BITS-1:0]   best_back_reg;
    logic [SLOT_W-1:0]     best_slot_reg;
    logic [BLOCK_BITS-1:0] best_block_reg;
    logic                  best_write_reg;
    logic [TAG_BITS-1:0]   best_tag_reg;

    logic [BLOCK_BITS-1:0] rd_block;
    logic                  rd_write;
    logic [TAG_BITS-1:0]   rd_tag;
    logic [AGE_BITS-1:0]   rd_age;
    logic [BLOCK_BITS-1:0] seek;
    logic                  above;
    logic [PRIM_W-1:0]     prim;
    logic [AGE_BITS-1:0]   back;
    logic                  key_vld;
    logic                  better;

    always_comb
    begin
        rd_block = rdata[BLOCK_BITS-1:0];
        rd_write = rdata[BLOCK_BITS];
        rd_tag   = rdata[BLOCK_BITS+1 +: TAG_BITS];
        rd_age   = rdata[BLOCK_BITS+1+TAG_BITS +: AGE_BITS];
        above    = rd_block > head;
        seek     = above ? (rd_block - head) : (head - rd_block);
        // Age is measured back from the arrival counter so it survives wrap.
        back     = arrival - rd_age;
        key_vld  = a_issue_reg.go && a_issue_reg.occupied;
        // Circular scan ranks blocks above the head first, then by block number.
        unique case (policy)
            POL_SSTF:  prim = {1'b0, seek};
            POL_CSCAN: prim = {~above, rd_block};
            default:   prim = '0;
        endcase
    end

    always_comb
    begin
        better = !found_reg || (b_prim_reg < best_prim_reg) ||
                 ((b_prim_reg == best_prim_reg) && (b_back_reg > best_back_reg));
        found_next = found_reg;
        if (start)
        begin
            found_next = 1'b0;
        end
        else if (b_vld_reg)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_issue_reg <= '0;
            b_vld_reg   <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            a_issue_reg <= issue;
            b_vld_reg   <= key_vld;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_slot_reg  <= issue_slot;
        b_prim_reg  <= prim;
        b_back_reg  <= back;
        b_slot_reg  <= a_slot_reg;
        b_block_reg <= rd_block;
        b_write_reg <= rd_write;
        b_tag_reg   <= rd_tag;
        if (b_vld_reg && better)
        begin
            best_prim_reg  <= b_prim_reg;
            best_back_reg  <= b_back_reg;
            best_slot_reg  <= b_slot_reg;
            best_block_reg <= b_block_reg;
            best_write_reg <= b_write_reg;
            best_tag_reg   <= b_tag_reg;
        end
    end

    assign busy       = a_issue_reg.go || b_vld_reg;
    assign found      = found_reg;
    assign best_slot  = best_slot_reg;
    assign best_block = best_block_reg;
    assign best_write = best_write_reg;
    assign best_tag   = best_tag_reg;

endmodule

// ----- bench/disk_request_scheduler_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for disk_request_scheduler_top: a directed table, then random phases
// with changing policy and disk size, each beat checked against a model or typed value.
// Depends on drs_pkg and the scheduler RTL.
module disk_request_scheduler_top_tb;
    import drs_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int BLOCK_BITS     = 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [POLICY_BITS-1:0] POL_UNUSED = 2'd3;
    localparam logic [BLOCK_BITS:0] DISK_MAX = 17'h10000;
    localparam logic [BLOCK_BITS:0] DISK_MIN = 17'h00001;
    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 155;
    localparam int PAUSE_PHASE    = 4;
    localparam int HOLD_BEAT      = 500;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = QUEUE_DEPTH + 10;

    typedef struct packed {
        logic [1:0]            kind;
        logic [BLOCK_BITS-1:0] block;
        logic                  wr;
        logic [TAG_BITS-1:0]   tag;
    } sched_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]    status;
        logic [BLOCK_BITS-1:0]     block;
        logic                      wr;
        logic [TAG_BITS-1:0]       tag;
        logic [BLOCK_BITS-1:0]     head;
        logic [STEP_BITS-1:0]      steps;
        logic [COUNT_OUT_BITS-1:0] count;
    } sched_grant_t;

    typedef struct {
        bit                  is_cfg;
        logic                cfg_idx;
        logic [BLOCK_BITS:0] cfg_value;
        sched_req_t          req;
        int                  reps;
        bit                  typed;
        sched_grant_t        typed_grant;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_en    = 1'b0;
    logic                      cfg_index = 1'b0;
    logic [BLOCK_BITS:0]       cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [1:0]                req_type  = '0;
    logic [BLOCK_BITS-1:0]     req_block = '0;
    logic                      req_write = 1'b0;
    logic [TAG_BITS-1:0]       req_tag   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STATUS_BITS-1:0]    status;
    logic [BLOCK_BITS-1:0]     grant_block;
    logic                      grant_write;
    logic [TAG_BITS-1:0]       grant_tag;
    logic [BLOCK_BITS-1:0]     cur_head;
    logic [STEP_BITS-1:0]      seek_total;
    logic [COUNT_OUT_BITS-1:0] pending_count;

    sched_grant_t pending_grants[$];
    int errors       = 0;
    int quiet_cycles = 0;
    bit no_idle      = 1'b0;

    // Scheduler model state.
    logic [POLICY_BITS-1:0] pred_policy    = POL_CSCAN;
    logic [BLOCK_BITS:0]    pred_disk_size = DISK_MAX;
    logic                   pred_valid [QUEUE_DEPTH] = '{default: 1'b0};
    logic [BLOCK_BITS-1:0]  pred_block [QUEUE_DEPTH];
    logic                   pred_write [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    pred_tag   [QUEUE_DEPTH];
    logic [AGE_BITS-1:0]    pred_age   [QUEUE_DEPTH];
    logic [AGE_BITS-1:0]    arrival_ctr = '0;
    logic                   svc_busy    = 1'b0;
    logic [BLOCK_BITS-1:0]  svc_block   = '0;
    logic                   svc_write   = 1'b0;
    logic [TAG_BITS-1:0]    svc_tag     = '0;
    logic [BLOCK_BITS-1:0]  head_block  = '0;
    logic [STEP_BITS-1:0]   step_total  = '0;

    disk_request_scheduler_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BLOCK_BITS  (BLOCK_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .req_block     (req_block),
        .req_write     (req_write),
        .req_tag       (req_tag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .grant_block   (grant_block),
        .grant_write   (grant_write),
        .grant_tag     (grant_tag),
        .cur_head      (cur_head),
        .seek_total    (seek_total),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Age is measured back from the arrival counter, so wrap does not disturb the order.
    function automatic logic [AGE_BITS-1:0] age_back(int i);
        return arrival_ctr - pred_age[i];
    endfunction

    function automatic bit older(int a, int b);
        return age_back(a) > age_back(b);
    endfunction

    function automatic logic [BLOCK_BITS-1:0] travel(logic [BLOCK_BITS-1:0] a,
                                                     logic [BLOCK_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit lower_wins(int i, int best);
        if (best < 0)
            return 1'b1;
        if (pred_block[i] != pred_block[best])
            return pred_block[i] < pred_block[best];
        return older(i, best);
    endfunction

    function automatic int select_entry();
        int best = -1;
        logic [BLOCK_BITS-1:0] d;
        if (pred_policy == POL_SSTF)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!pred_valid[i])
                    continue;
                d = travel(pred_block[i], head_block);
                if (best < 0 || d < travel(pred_block[best], head_block) ||
                    (d == travel(pred_block[best], head_block) && older(i, best)))
                    best = i;
            end
        end
        else if (pred_policy == POL_CSCAN)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (pred_valid[i] && pred_block[i] > head_block && lower_wins(i, best))
                    best = i;
            // Nothing above the head: sweep back to the lowest block.
            if (best < 0)
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (pred_valid[i] && lower_wins(i, best))
                        best = i;
        end
        else
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
                if (pred_valid[i] && (best < 0 || older(i, best)))
                    best = i;
        end
        return best;
    endfunction

    function automatic sched_grant_t schedule_step(sched_req_t r);
        sched_grant_t g;
        int slot = -1;
        int sel;
        logic [STEP_BITS-1:0] d;
        g = '0;
        g.status = ST_ERROR;
        if (r.kind == REQ_ENQUEUE)
        begin
            if ({1'b0, r.block} < pred_disk_size)
            begin
                for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
                    if (!pred_valid[i])
                        slot = i;
                if (slot < 0)
                    g.status = ST_FULL;
                else
                begin
                    pred_valid[slot] = 1'b1;
                    pred_block[slot] = r.block;
                    pred_write[slot] = r.wr;
                    pred_tag[slot]   = r.tag;
                    pred_age[slot]   = arrival_ctr;
                    arrival_ctr      = arrival_ctr + 1'b1;
                    g.status         = ST_ACCEPTED;
                end
            end
        end
        else if (r.kind == REQ_DISPATCH)
        begin
            if (svc_busy)
                g.status = ST_BUSY;
            else
            begin
                sel = select_entry();
                if (sel < 0)
                    g.status = ST_EMPTY;
                else
                begin
                    pred_valid[sel] = 1'b0;
                    svc_busy  = 1'b1;
                    svc_block = pred_block[sel];
                    svc_write = pred_write[sel];
                    svc_tag   = pred_tag[sel];
                    g.block   = svc_block;
                    g.wr      = svc_write;
                    g.tag     = svc_tag;
                    g.status  = ST_DISPATCHED;
                end
            end
        end
        else if (r.kind == REQ_COMPLETE && svc_busy)
        begin
            d = STEP_BITS'(travel(head_block, svc_block));
            step_total = (step_total > STEP_MAX - d) ? STEP_MAX : step_total + d;
            head_block = svc_block;
            g.block    = svc_block;
            g.wr       = svc_write;
            g.tag      = svc_tag;
            g.status   = ST_COMPLETED;
            svc_busy   = 1'b0;
            svc_block  = '0;
            svc_write  = 1'b0;
            svc_tag    = '0;
        end
        g.head  = head_block;
        g.steps = step_total;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            if (pred_valid[i])
                g.count = g.count + 1'b1;
        return g;
    endfunction

    function automatic sched_req_t make_req(logic [1:0] kind, logic [BLOCK_BITS-1:0] blk,
                                            logic wr, logic [TAG_BITS-1:0] tag);
        sched_req_t r;
        r.kind  = kind;
        r.block = blk;
        r.wr    = wr;
        r.tag   = tag;
        return r;
    endfunction

    function automatic sched_grant_t outcome(logic [STATUS_BITS-1:0] st,
                                             logic [BLOCK_BITS-1:0] blk, logic wr,
                                             logic [TAG_BITS-1:0] tag,
                                             logic [BLOCK_BITS-1:0] head,
                                             logic [STEP_BITS-1:0] steps,
                                             logic [COUNT_OUT_BITS-1:0] count);
        return {st, blk, wr, tag, head, steps, count};
    endfunction

    function automatic stim_row_t item_row(logic [1:0] kind, logic [BLOCK_BITS-1:0] blk,
                                           logic wr, logic [TAG_BITS-1:0] tag, int reps);
        stim_row_t row;
        row.is_cfg      = 1'b0;
        row.cfg_idx     = CFG_POLICY;
        row.cfg_value   = '0;
        row.req         = make_req(kind, blk, wr, tag);
        row.reps        = reps;
        row.typed       = 1'b0;
        row.typed_grant = '0;
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic [1:0] kind, logic [BLOCK_BITS-1:0] blk,
                                              logic wr, logic [TAG_BITS-1:0] tag,
                                              sched_grant_t g);
        stim_row_t row;
        row             = item_row(kind, blk, wr, tag, 1);
        row.typed       = 1'b1;
        row.typed_grant = g;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic idx, logic [BLOCK_BITS:0] value);
        stim_row_t row;
        row           = item_row(REQ_ENQUEUE, '0, 1'b0, '0, 0);
        row.is_cfg    = 1'b1;
        row.cfg_idx   = idx;
        row.cfg_value = value;
        return row;
    endfunction

    // Mostly in range, with a bias toward low blocks and the top block so that ties occur.
    function automatic logic [BLOCK_BITS-1:0] draw_block();
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = int'(pred_disk_size) - 1;
        if (roll < 60)
            return BLOCK_BITS'($urandom_range(0, top));
        if (roll < 80)
            return BLOCK_BITS'($urandom_range(0, (top < 7) ? top : 7));
        if (roll < 88)
            return BLOCK_BITS'(top);
        return BLOCK_BITS'($urandom);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_grant(sched_grant_t want, sched_grant_t got);
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("grant_block", 64'(want.block), 64'(got.block));
        check_field("grant_write", 64'(want.wr), 64'(got.wr));
        check_field("grant_tag", 64'(want.tag), 64'(got.tag));
        check_field("cur_head", 64'(want.head), 64'(got.head));
        check_field("seek_total", 64'(want.steps), 64'(got.steps));
        check_field("pending_count", 64'(want.count), 64'(got.count));
    endtask

    task automatic write_register(logic idx, logic [BLOCK_BITS:0] value);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_en <= 1'b0;
        if (idx == CFG_POLICY)
            pred_policy = value[POLICY_BITS-1:0];
        else
            pred_disk_size = value;
        @(posedge clk);
    endtask

    task automatic wait_idle(int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_grants.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic send_item(sched_req_t r, bit typed, sched_grant_t typed_grant);
        int gap;
        bit taken;
        sched_grant_t g;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= r.kind;
        req_block <= r.block;
        req_write <= r.wr;
        req_tag   <= r.tag;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        g = schedule_step(r);
        pending_grants.push_back(typed ? typed_grant : g);
    endtask

    initial
    begin : stimulus
        stim_row_t rows[$];
        sched_req_t r;
        logic [BLOCK_BITS:0] disk;
        logic [BLOCK_BITS:0] cfg_word;
        int sent;
        int burst;
        int pairs;
        bit paused;

        rows.push_back(checked_row(REQ_DISPATCH, '0, 1'b0, '0,
                                   outcome(ST_EMPTY, '0, 1'b0, '0, '0, '0, 5'd0)));
        rows.push_back(checked_row(REQ_COMPLETE, '0, 1'b0, '0,
                                   outcome(ST_ERROR, '0, 1'b0, '0, '0, '0, 5'd0)));
        rows.push_back(checked_row(REQ_UNUSED, 16'hFFFF, 1'b1, 8'hFF,
                                   outcome(ST_ERROR, '0, 1'b0, '0, '0, '0, 5'd0)));
        rows.push_back(checked_row(REQ_ENQUEUE, 16'hFFFF, 1'b1, 8'hFF,
                                   outcome(ST_ACCEPTED, '0, 1'b0, '0, '0, '0, 5'd1)));
        rows.push_back(checked_row(REQ_ENQUEUE, 16'h0000, 1'b0, 8'h00,
                                   outcome(ST_ACCEPTED, '0, 1'b0, '0, '0, '0, 5'd2)));
        rows.push_back(item_row(REQ_ENQUEUE, 16'd100, 1'b1, 8'h5A, 1));
        rows.push_back(item_row(REQ_DISPATCH, '0, 1'b0, '0, 1));
        rows.push_back(checked_row(REQ_DISPATCH, '0, 1'b0, '0,
                                   outcome(ST_BUSY, '0, 1'b0, '0, '0, '0, 5'd2)));
        rows.push_back(item_row(REQ_COMPLETE, '0, 1'b0, '0, 1));
        rows.push_back(item_row(REQ_DISPATCH, '0, 1'b0, '0, 1));
        rows.push_back(item_row(REQ_COMPLETE, '0, 1'b0, '0, 1));
        // The scan has run past every request, so it wraps to the lowest block.
        rows.push_back(item_row(REQ_DISPATCH, '0, 1'b0, '0, 1));
        rows.push_back(item_row(REQ_COMPLETE, '0, 1'b0, '0, 1));
        rows.push_back(cfg_row(CFG_NUM_BLOCKS, DISK_MIN));
        rows.push_back(cfg_row(CFG_POLICY, {15'd0, POL_SSTF}));
        rows.push_back(item_row(REQ_ENQUEUE, 16'd1, 1'b0, 8'h03, 1));
        rows.push_back(item_row(REQ_ENQUEUE, 16'hFFFF, 1'b1, 8'h04, 1));
        rows.push_back(item_row(REQ_ENQUEUE, 16'd0, 1'b1, 8'h10, QUEUE_DEPTH));
        rows.push_back(item_row(REQ_ENQUEUE, 16'd0, 1'b0, 8'h20, 1));
        // Out of range beats full when both apply.
        rows.push_back(item_row(REQ_ENQUEUE, 16'd2, 1'b0, 8'h21, 1));
        rows.push_back(cfg_row(CFG_POLICY, {15'd0, POL_UNUSED}));
        rows.push_back(cfg_row(CFG_NUM_BLOCKS, DISK_MAX));
        rows.push_back(item_row(REQ_DISPATCH, '0, 1'b0, '0, 1));
        rows.push_back(item_row(REQ_COMPLETE, '0, 1'b0, '0, 1));
        rows.push_back(cfg_row(CFG_POLICY, {15'd0, POL_FCFS}));
        rows.push_back(item_row(REQ_ENQUEUE, 16'd40000, 1'b1, 8'hA5, 1));
        rows.push_back(item_row(REQ_DISPATCH, '0, 1'b0, '0, 1));
        rows.push_back(item_row(REQ_COMPLETE, '0, 1'b0, '0, 1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[n])
        begin
            if (rows[n].is_cfg)
            begin
                wait_idle(SETTLE_CYCLES);
                write_register(rows[n].cfg_idx, rows[n].cfg_value);
            end
            else
            begin
                for (int k = 0; k < rows[n].reps; k++)
                begin
                    r     = rows[n].req;
                    r.tag = r.tag + k[TAG_BITS-1:0];
                    send_item(r, rows[n].typed, rows[n].typed_grant);
                end
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle(SETTLE_CYCLES);
            case (p % 5)
                0:       disk = DISK_MAX;
                1:       disk = DISK_MIN;
                2:       disk = (BLOCK_BITS+1)'($urandom_range(2, 64));
                3:       disk = (BLOCK_BITS+1)'($urandom_range(1, 65536));
                default: disk = DISK_MAX - 1'b1;
            endcase
            // Bits above the policy field are don't-care to the block.
            cfg_word = (BLOCK_BITS+1)'($urandom);
            cfg_word[POLICY_BITS-1:0] = p[POLICY_BITS-1:0];
            write_register(CFG_POLICY, cfg_word);
            write_register(CFG_NUM_BLOCKS, disk);
            no_idle = (p % 3 == 2);
            sent    = 0;
            paused  = 1'b0;
            while (sent < PHASE_ITEMS)
            begin
                if (p == PAUSE_PHASE && !paused && sent >= PHASE_ITEMS / 2)
                begin
                    wait_idle(0);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    r = make_req(2'($urandom_range(0, 3)), BLOCK_BITS'($urandom),
                                 1'($urandom_range(0, 1)),
                                 TAG_BITS'($urandom_range(0, 255)));
                    send_item(r, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // A burst of requests, then dispatch and completion pairs.
                    burst = (p % 2) ? $urandom_range(0, 3) : $urandom_range(1, 6);
                    pairs = $urandom_range(1, 3);
                    repeat (burst)
                    begin
                        r = make_req(REQ_ENQUEUE, draw_block(), 1'($urandom_range(0, 1)),
                                     TAG_BITS'($urandom_range(0, 255)));
                        send_item(r, 1'b0, '0);
                    end
                    repeat (pairs)
                    begin
                        send_item(make_req(REQ_DISPATCH, BLOCK_BITS'($urandom), 1'b0, '0),
                                  1'b0, '0);
                        send_item(make_req(REQ_COMPLETE, '0, 1'($urandom_range(0, 1)), '0),
                                  1'b0, '0);
                    end
                    sent += burst + 2 * pairs;
                end
            end
        end

        no_idle = 1'b0;
        wait_idle(END_CYCLES);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : result_sink
        int hold;
        bit got;
        sched_grant_t seen;
        int beats;
        beats = 0;
        wait (rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 3);
            // One long hold-off so the block backs up and stalls its input.
            if (beats == HOLD_BEAT)
                hold = HOLD_CYCLES;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got  = out_valid;
                seen = {status, grant_block, grant_write, grant_tag, cur_head,
                        seek_total, pending_count};
                @(posedge clk);
            end
            while (!got);
            beats++;
            if (pending_grants.size() == 0)
            begin
                $error("result beat arrived with no request outstanding");
                errors++;
            end
            else
                check_grant(pending_grants.pop_front(), seen);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
